>>> hdl/bpm_pkg.sv
`default_nettype none

package bpm_pkg;

  localparam int DATA_W     = 8;
  localparam int OUT_W      = 32;
  localparam int LEN_W      = 6;
  localparam int PAT_BYTES  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int WORD_BYTES = 8;

  localparam logic [DATA_W-1:0] PRINT_LO = 8'h20;
  localparam logic [DATA_W-1:0] PRINT_HI = 8'h7E;
  localparam logic [DATA_W-1:0] UPPER_A  = 8'h41;
  localparam logic [DATA_W-1:0] UPPER_Z  = 8'h5A;
  localparam logic [DATA_W-1:0] CASE_GAP = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_LENGTH = 3'd1,
    REG_WORD0  = 3'd2,
    REG_WORD1  = 3'd3,
    REG_WORD2  = 3'd4,
    REG_WORD3  = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    MODE_TEXT  = 1'b0,
    MODE_EXACT = 1'b1
  } match_mode_t;

  typedef struct packed {
    match_mode_t                     mode;
    logic [LEN_W-1:0]                length;
    logic [PAT_BYTES*DATA_W-1:0]     pattern;
  } cfg_t;

  function automatic logic [DATA_W-1:0] fold(input logic [DATA_W-1:0] c);
    if (c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_GAP;
    end
    return c;
  endfunction

  function automatic logic is_printable(input logic [DATA_W-1:0] c);
    return (c >= PRINT_LO) && (c <= PRINT_HI);
  endfunction

endpackage

`default_nettype wire

>>> hdl/bpm_if.sv
`default_nettype none

interface bpm_in_if;
  logic                       valid;
  logic                       ready;
  logic [bpm_pkg::DATA_W-1:0] data_byte;
  logic                       end_of_buffer;
  modport source(output valid, data_byte, end_of_buffer, input ready);
  modport sink(input valid, data_byte, end_of_buffer, output ready);
endinterface

interface bpm_out_if;
  logic                      valid;
  logic                      ready;
  logic [bpm_pkg::OUT_W-1:0] match_offset;
  logic [bpm_pkg::OUT_W-1:0] run_start;
  modport source(output valid, match_offset, run_start, input ready);
  modport sink(input valid, match_offset, run_start, output ready);
endinterface

interface bpm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bpm_pkg::CFG_IDX_W-1:0]  index;
  logic [bpm_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/bpm_cfg_regs.sv
`default_nettype none

module bpm_cfg_regs (
  input  wire logic      clk,
  input  wire logic      rst_n,
  bpm_cfg_if.sink        cfg_bus,
  output bpm_pkg::cfg_t  cfg
);

  localparam int WORD_W = bpm_pkg::CFG_DATA_W;

  bpm_pkg::match_mode_t                              mode_r, mode_nxt;
  logic [bpm_pkg::LEN_W-1:0]                         length_r, length_nxt;
  logic [bpm_pkg::PAT_BYTES*bpm_pkg::DATA_W-1:0]     pattern_r, pattern_nxt;
  logic                                              wr;

  assign cfg_bus.ready = 1'b1;
  assign wr = cfg_bus.valid;

  always_comb begin
    mode_nxt    = mode_r;
    length_nxt  = length_r;
    pattern_nxt = pattern_r;
    if (wr) begin
      unique case (bpm_pkg::cfg_reg_t'(cfg_bus.index))
        bpm_pkg::REG_MODE:   mode_nxt = bpm_pkg::match_mode_t'(cfg_bus.data[0]);
        bpm_pkg::REG_LENGTH: length_nxt = cfg_bus.data[bpm_pkg::LEN_W-1:0];
        bpm_pkg::REG_WORD0:  pattern_nxt[0*WORD_W +: WORD_W] = cfg_bus.data;
        bpm_pkg::REG_WORD1:  pattern_nxt[1*WORD_W +: WORD_W] = cfg_bus.data;
        bpm_pkg::REG_WORD2:  pattern_nxt[2*WORD_W +: WORD_W] = cfg_bus.data;
        bpm_pkg::REG_WORD3:  pattern_nxt[3*WORD_W +: WORD_W] = cfg_bus.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= bpm_pkg::MODE_TEXT;
      length_r  <= bpm_pkg::LEN_W'(1);
      pattern_r <= '0;
    end else begin
      mode_r    <= mode_nxt;
      length_r  <= length_nxt;
      pattern_r <= pattern_nxt;
    end
  end

  assign cfg.mode    = mode_r;
  assign cfg.length  = length_r;
  assign cfg.pattern = pattern_r;

endmodule

`default_nettype wire

>>> hdl/bpm_match.sv
`default_nettype none

module bpm_match #(
  parameter int MAX_PATTERN = 32
) (
  input  wire bpm_pkg::match_mode_t                          mode,
  input  wire logic [bpm_pkg::LEN_W-1:0]                     len,
  input  wire logic [bpm_pkg::PAT_BYTES*bpm_pkg::DATA_W-1:0] pattern,
  input  wire logic [MAX_PATTERN-1:0][bpm_pkg::DATA_W-1:0]   window,
  output logic                                               hit
);

  localparam int PIDX_W = $clog2(bpm_pkg::PAT_BYTES);

  logic [bpm_pkg::PAT_BYTES-1:0][bpm_pkg::DATA_W-1:0] pat_bytes;
  logic [MAX_PATTERN-1:0]                             lane_ok;
  logic [bpm_pkg::LEN_W-1:0]                          pidx [MAX_PATTERN];
  logic [bpm_pkg::DATA_W-1:0]                         wb [MAX_PATTERN];
  logic [bpm_pkg::DATA_W-1:0]                         pb [MAX_PATTERN];

  assign pat_bytes = pattern;

  // Window entry i holds the byte that pairs with pattern byte len-1-i.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pidx[i] = len - bpm_pkg::LEN_W'(i + 1);
      wb[i]   = window[i];
      pb[i]   = pat_bytes[pidx[i][PIDX_W-1:0]];
      if (mode == bpm_pkg::MODE_TEXT) begin
        wb[i] = bpm_pkg::fold(wb[i]);
        pb[i] = bpm_pkg::fold(pb[i]);
      end
      lane_ok[i] = (bpm_pkg::LEN_W'(i) >= len) || (wb[i] == pb[i]);
    end
  end

  assign hit = (len != '0) && (&lane_ok);

endmodule

`default_nettype wire

>>> hdl/byte_pattern_matcher.sv
// Channel  Direction  Payload                          Beat when
// in_bus   input      data_byte[8], end_of_buffer[1]   valid && ready
// out_bus  output     match_offset[32], run_start[32]  valid && ready
// cfg_bus  input      index[3], data[64]               valid && ready (always ready)
//
// One byte per cycle is sustained while out_bus is not stalled.
// The input register and the result register bound one stage of window compare logic.
// A stalled result holds the compare stage, and the input register then fills and drops ready.
// Reset is synchronous and active low; it clears the stream state and the valid flags.
`default_nettype none

module byte_pattern_matcher #(
  parameter int MAX_PATTERN = 32,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bpm_in_if.sink     in_bus,
  bpm_out_if.source  out_bus,
  bpm_cfg_if.sink    cfg_bus
);

  localparam int DW = bpm_pkg::DATA_W;
  localparam int LW = bpm_pkg::LEN_W;

  bpm_pkg::cfg_t cfg;

  logic                   in_valid_r, in_valid_nxt;
  logic [DW-1:0]          in_byte_r;
  logic                   in_last_r;
  logic                   in_beat;
  logic                   proc;

  logic [MAX_PATTERN-1:0][DW-1:0] win_r, win_sh;
  logic [MAX_PATTERN-1:0]         prn_r, prn_sh;
  logic [OFFSET_BITS-1:0]         count_r, count_nxt;
  logic [OFFSET_BITS-1:0]         lnp_r, lnp_nxt, lnp_upd;
  logic                           none_r, none_nxt, none_upd;

  logic                   out_valid_r, out_valid_nxt;
  logic [bpm_pkg::OUT_W-1:0] offset_r, run_r;

  logic [LW-1:0]          len;
  logic                   leave;
  logic                   pos_ok;
  logic                   bytes_hit;
  logic                   hit;
  logic                   found;
  logic [LW-1:0]          k_sel;
  logic [OFFSET_BITS-1:0] start;
  logic [OFFSET_BITS-1:0] run;

  bpm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .cfg     (cfg)
  );

  assign proc          = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready  = !in_valid_r || proc;
  assign in_beat       = in_bus.valid && in_bus.ready;
  assign in_valid_nxt  = in_beat || (in_valid_r && !proc);

  always_ff @(posedge clk) begin
    if (in_beat) begin
      in_byte_r <= in_bus.data_byte;
      in_last_r <= in_bus.end_of_buffer;
    end
  end

  always_comb begin
    win_sh[0] = in_byte_r;
    prn_sh[0] = bpm_pkg::is_printable(in_byte_r);
    for (int i = 1; i < MAX_PATTERN; i++) begin
      win_sh[i] = win_r[i-1];
      prn_sh[i] = prn_r[i-1];
    end
  end

  assign len = (cfg.length > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : cfg.length;

  bpm_match #(.MAX_PATTERN(MAX_PATTERN)) u_match (
    .mode    (cfg.mode),
    .len     (len),
    .pattern (cfg.pattern),
    .window  (win_sh),
    .hit     (bytes_hit)
  );

  assign leave    = (count_r >= OFFSET_BITS'(MAX_PATTERN)) && !prn_r[MAX_PATTERN-1];
  assign lnp_upd  = leave ? count_r - OFFSET_BITS'(MAX_PATTERN) : lnp_r;
  assign none_upd = none_r && !leave;
  assign pos_ok   = (len != '0) && (count_r >= OFFSET_BITS'(len - LW'(1)));
  assign hit      = proc && pos_ok && bytes_hit;
  assign start    = count_r - OFFSET_BITS'(len - LW'(1));

  // The first non-printable entry at or past the match start sets the run start.
  always_comb begin
    found = 1'b0;
    k_sel = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (!found && (LW'(k + 1) >= len) && (OFFSET_BITS'(k) <= count_r) && !prn_sh[k]) begin
        found = 1'b1;
        k_sel = LW'(k);
      end
    end
  end

  always_comb begin
    run = '0;
    if (cfg.mode == bpm_pkg::MODE_TEXT) begin
      if (found) begin
        run = count_r - OFFSET_BITS'(k_sel) + OFFSET_BITS'(1);
      end else if (!none_upd) begin
        run = lnp_upd + OFFSET_BITS'(1);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    lnp_nxt   = lnp_r;
    none_nxt  = none_r;
    if (proc) begin
      if (in_last_r) begin
        count_nxt = '0;
        lnp_nxt   = '0;
        none_nxt  = 1'b1;
      end else begin
        count_nxt = (count_r != '1) ? count_r + OFFSET_BITS'(1) : count_r;
        lnp_nxt   = lnp_upd;
        none_nxt  = none_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      win_r <= win_sh;
      prn_r <= prn_sh;
    end
  end

  assign out_valid_nxt = proc ? hit : (out_valid_r && !out_bus.ready);

  always_ff @(posedge clk) begin
    if (hit) begin
      offset_r <= bpm_pkg::OUT_W'(start);
      run_r    <= bpm_pkg::OUT_W'(run);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      lnp_r       <= '0;
      none_r      <= 1'b1;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      lnp_r       <= lnp_nxt;
      none_r      <= none_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.match_offset = offset_r;
  assign out_bus.run_start    = run_r;

endmodule

`default_nettype wire

>>> hdl/bpm_checker.sv
`default_nettype none

module bpm_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [bpm_pkg::OUT_W-1:0] match_offset,
  input wire logic [bpm_pkg::OUT_W-1:0] run_start
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(match_offset) && $stable(run_start))
    else $error("result payload changed while stalled");

  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, run_start} <= ({1'b0, match_offset} + 33'd1)))
    else $error("run start lies past the match start");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

endmodule

bind byte_pattern_matcher bpm_checker u_bpm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .match_offset (out_bus.match_offset),
  .run_start    (out_bus.run_start)
);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [bpm_pkg::OUT_W-1:0] offset;
    logic [bpm_pkg::OUT_W-1:0] run;
  } match_t;

  logic clk = 1'b0;
  logic rst_n;

  bpm_in_if  in_bus();
  bpm_out_if out_bus();
  bpm_cfg_if cfg_bus();

  byte_pattern_matcher u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bpm_pkg::match_mode_t             cur_mode;
  logic [bpm_pkg::LEN_W-1:0]        cur_len;
  logic [bpm_pkg::PAT_BYTES*8-1:0]  cur_pattern;
  logic [7:0]                       win_byte [bpm_pkg::PAT_BYTES];
  logic                             win_print [bpm_pkg::PAT_BYTES];
  logic [bpm_pkg::OUT_W-1:0]        byte_pos;
  logic [bpm_pkg::OUT_W-1:0]        last_np_pos;
  logic                             np_seen;

  match_t pending_matches [$];

  int bytes_sent = 0;
  int buffers_sent = 0;
  int settings_loaded = 0;
  int matches_checked = 0;
  int mismatches = 0;
  int src_idle_pct = 28;
  int sink_idle_pct = 28;
  int hold_len = 0;
  logic hold_req = 1'b0;

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endtask

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] flip_case(input logic [7:0] c);
    if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(1)) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  task automatic reset_stream();
    for (int i = 0; i < bpm_pkg::PAT_BYTES; i++) begin
      win_byte[i] = '0;
      win_print[i] = 1'b0;
    end
    byte_pos = '0;
    last_np_pos = '0;
    np_seen = 1'b0;
  endtask

  task automatic apply_reg(input bpm_pkg::cfg_reg_t idx,
                           input logic [bpm_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      bpm_pkg::REG_MODE:   cur_mode = bpm_pkg::match_mode_t'(v[0]);
      bpm_pkg::REG_LENGTH: cur_len = v[bpm_pkg::LEN_W-1:0];
      bpm_pkg::REG_WORD0:  cur_pattern[0*64 +: 64] = v;
      bpm_pkg::REG_WORD1:  cur_pattern[1*64 +: 64] = v;
      bpm_pkg::REG_WORD2:  cur_pattern[2*64 +: 64] = v;
      bpm_pkg::REG_WORD3:  cur_pattern[3*64 +: 64] = v;
      default: ;
    endcase
  endtask

  // Shifts one byte into the window and queues the match it completes, if any.
  task automatic search_byte(input logic [7:0] b, input logic eob);
    longint unsigned pos;
    int len;
    int k;
    logic hit;
    logic found;
    logic [7:0] w;
    logic [7:0] p;
    match_t m;
    pos = byte_pos;
    if (pos >= bpm_pkg::PAT_BYTES && !win_print[bpm_pkg::PAT_BYTES-1]) begin
      last_np_pos = bpm_pkg::OUT_W'(pos - bpm_pkg::PAT_BYTES);
      np_seen = 1'b1;
    end
    for (k = bpm_pkg::PAT_BYTES - 1; k > 0; k--) begin
      win_byte[k] = win_byte[k-1];
      win_print[k] = win_print[k-1];
    end
    win_byte[0] = b;
    win_print[0] = (b >= bpm_pkg::PRINT_LO) && (b <= bpm_pkg::PRINT_HI);
    len = (cur_len > bpm_pkg::PAT_BYTES) ? bpm_pkg::PAT_BYTES : int'(cur_len);
    if (len > 0 && pos >= longint'(len - 1)) begin
      hit = 1'b1;
      for (int j = 0; j < len; j++) begin
        w = win_byte[len-1-j];
        p = cur_pattern[j*8 +: 8];
        if (cur_mode == bpm_pkg::MODE_TEXT) begin
          w = to_lower(w);
          p = to_lower(p);
        end
        if (w != p) begin
          hit = 1'b0;
          break;
        end
      end
      if (hit) begin
        m.offset = bpm_pkg::OUT_W'(pos - (len - 1));
        m.run = '0;
        if (cur_mode == bpm_pkg::MODE_TEXT) begin
          found = 1'b0;
          for (k = len - 1; k < bpm_pkg::PAT_BYTES && k <= pos; k++) begin
            if (!win_print[k]) begin
              m.run = bpm_pkg::OUT_W'(pos - k + 1);
              found = 1'b1;
              break;
            end
          end
          if (!found && np_seen) begin
            m.run = last_np_pos + 1;
          end
        end
        pending_matches.insert(pending_matches.size(), m);
      end
    end
    if (byte_pos != '1) begin
      byte_pos = byte_pos + 1;
    end
    if (eob) begin
      reset_stream();
    end
  endtask

  always @(posedge clk) begin
    match_t m;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_matches.size() == 0) begin
        note_error($sformatf("unexpected match offset=%0d run=%0d",
                             out_bus.match_offset, out_bus.run_start));
      end else begin
        m = pending_matches.pop_front();
        matches_checked++;
        if (out_bus.match_offset !== m.offset) begin
          note_error($sformatf("match_offset expected %0d got %0d",
                               m.offset, out_bus.match_offset));
        end
        if (out_bus.run_start !== m.run) begin
          note_error($sformatf("run_start expected %0d got %0d (offset %0d)",
                               m.run, out_bus.run_start, m.offset));
        end
      end
    end
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (hold_len) begin
          out_bus.ready = 1'b0;
          @(negedge clk);
        end
      end
      out_bus.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.data_byte = b;
    in_bus.end_of_buffer = eob;
    do @(posedge clk); while (!in_bus.ready);
    search_byte(b, eob);
    bytes_sent++;
    if (eob) begin
      buffers_sent++;
    end
  endtask

  // Waits until every queued match has arrived and the pipeline has emptied.
  task automatic drain();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_matches.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input bpm_pkg::cfg_reg_t idx,
                           input logic [bpm_pkg::CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = v;
    do @(posedge clk); while (!cfg_bus.ready);
    apply_reg(idx, v);
  endtask

  task automatic load_settings(input bpm_pkg::match_mode_t m,
                               input logic [bpm_pkg::LEN_W-1:0] len,
                               input logic [bpm_pkg::PAT_BYTES*8-1:0] pat);
    drain();
    write_reg(bpm_pkg::REG_MODE, bpm_pkg::CFG_DATA_W'(m));
    write_reg(bpm_pkg::REG_LENGTH, bpm_pkg::CFG_DATA_W'(len));
    write_reg(bpm_pkg::REG_WORD0, pat[0*64 +: 64]);
    write_reg(bpm_pkg::REG_WORD1, pat[1*64 +: 64]);
    write_reg(bpm_pkg::REG_WORD2, pat[2*64 +: 64]);
    write_reg(bpm_pkg::REG_WORD3, pat[3*64 +: 64]);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
    settings_loaded++;
  endtask

  function automatic logic [bpm_pkg::PAT_BYTES*8-1:0] make_pattern();
    logic [bpm_pkg::PAT_BYTES*8-1:0] pat;
    logic [7:0] alphabet [10];
    int sel;
    alphabet = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h7A, 8'h5A, 8'h40, 8'h5B, 8'h00, 8'h7F};
    sel = $urandom_range(7);
    if (sel == 0) begin
      return '0;
    end
    if (sel == 1) begin
      return '1;
    end
    for (int i = 0; i < bpm_pkg::PAT_BYTES; i++) begin
      if ($urandom_range(3) == 0) begin
        pat[i*8 +: 8] = 8'($urandom_range(255));
      end else begin
        pat[i*8 +: 8] = alphabet[$urandom_range(9)];
      end
    end
    return pat;
  endfunction

  task automatic send_buffer(input int len, input int blen, input int noise, input logic close);
    int k;
    int r;
    logic [7:0] b;
    k = 0;
    while (k < blen) begin
      if (len > 0 && k + len <= blen && $urandom_range(4) == 0) begin
        for (int j = 0; j < len; j++) begin
          b = cur_pattern[j*8 +: 8];
          if (cur_mode == bpm_pkg::MODE_TEXT) begin
            b = flip_case(b);
          end
          send_byte(b, close && (k + j == blen - 1));
        end
        k += len;
      end else begin
        r = $urandom_range(99);
        if (r < noise) begin
          b = 8'($urandom_range(255));
        end else if (r < noise + 45 && len > 0) begin
          b = flip_case(cur_pattern[$urandom_range(len - 1)*8 +: 8]);
        end else begin
          b = 8'($urandom_range(bpm_pkg::PRINT_HI, bpm_pkg::PRINT_LO));
        end
        send_byte(b, close && (k == blen - 1));
        k++;
      end
    end
  endtask

  task automatic test_directed_cases();
    // Reset settings: text mode, one pattern byte of zero.
    send_byte(8'h00, 1'b1);
    load_settings(bpm_pkg::MODE_TEXT, 6'd3, 256'h634261);
    send_byte(8'h1F, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h63, 1'b1);
    // Only A-Z fold, so the neighbors of the letter ranges must not match.
    load_settings(bpm_pkg::MODE_TEXT, 6'd2, 256'h7A5B);
    send_byte(8'h7B, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(8'h5A, 1'b1);
    load_settings(bpm_pkg::MODE_EXACT, 6'd2, 256'h6241);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'hFF, 1'b1);
    load_settings(bpm_pkg::MODE_TEXT, 6'd0, '0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    load_settings(bpm_pkg::MODE_EXACT, 6'd1, '1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h20, 1'b1);
  endtask

  task automatic test_output_backpressure();
    load_settings(bpm_pkg::MODE_TEXT, 6'd1, 256'h61);
    src_idle_pct = 0;
    hold_len = 200;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_byte(8'h61, i == 39);
    end
    src_idle_pct = 28;
  endtask

  task automatic test_paused_sender();
    load_settings(bpm_pkg::MODE_EXACT, 6'd2, 256'h6261);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    drain();
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b0);
    drain();
    send_byte(8'h62, 1'b1);
  endtask

  task automatic test_random_traffic();
    bpm_pkg::match_mode_t m;
    logic [bpm_pkg::LEN_W-1:0] len;
    int eff;
    int phase;
    int blen;
    int noise;
    phase = 0;
    while (bytes_sent < 1950) begin
      m = bpm_pkg::match_mode_t'($urandom_range(1));
      case ($urandom_range(9))
        0:       len = $urandom_range(1) ? 6'd0 : bpm_pkg::LEN_W'($urandom_range(63, 33));
        1, 2:    len = bpm_pkg::LEN_W'($urandom_range(32, 5));
        default: len = bpm_pkg::LEN_W'($urandom_range(4, 1));
      endcase
      if (phase == 1) begin
        len = 6'd32;
      end else if (phase == 2) begin
        len = 6'd63;
      end
      load_settings(m, len, make_pattern());
      src_idle_pct = (phase % 6 == 3) ? 0 : 28;
      sink_idle_pct = src_idle_pct;
      eff = (len > bpm_pkg::PAT_BYTES) ? bpm_pkg::PAT_BYTES : int'(len);
      repeat ($urandom_range(4, 1)) begin
        blen = ($urandom_range(9) == 0) ? $urandom_range(160, 60) : $urandom_range(40, 1);
        case ($urandom_range(2))
          0:       noise = 0;
          1:       noise = 4;
          default: noise = 20;
        endcase
        send_buffer(eff, blen, noise, $urandom_range(9) != 0);
      end
      phase++;
    end
    src_idle_pct = 28;
    sink_idle_pct = 28;
  endtask

  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    in_bus.end_of_buffer = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = bpm_pkg::REG_MODE;
    cfg_bus.data = '0;
    cur_mode = bpm_pkg::MODE_TEXT;
    cur_len = 6'd1;
    cur_pattern = '0;
    reset_stream();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_output_backpressure();
    test_paused_sender();
    test_random_traffic();

    drain();
    repeat (10) @(posedge clk);
    if (pending_matches.size() != 0) begin
      note_error($sformatf("%0d matches never arrived", pending_matches.size()));
    end
    $display("Searched %0d bytes in %0d closed buffers under %0d register settings.",
             bytes_sent, buffers_sent, settings_loaded);
    $display("Checked %0d reported matches, %0d mismatches.", matches_checked, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run did not complete in time.");
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
hdl/bpm_pkg.sv
hdl/bpm_if.sv
hdl/bpm_cfg_regs.sv
hdl/bpm_match.sv
hdl/byte_pattern_matcher.sv
hdl/bpm_checker.sv
tb/tb.sv
